// ----- design/sobet_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sobet_pkg;

  localparam int PIXEL_W   = 8;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  typedef logic [PIXEL_W-1:0]   pixel_t;
  typedef logic [CFG_W-1:0]     cfg_data_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // register indexes of the configuration port
  localparam cfg_idx_t REG_IMAGE_WIDTH  = 2'd0;
  localparam cfg_idx_t REG_IMAGE_HEIGHT = 2'd1;

  localparam cfg_data_t IMAGE_WIDTH_RST  = 11'd640;
  localparam cfg_data_t IMAGE_HEIGHT_RST = 11'd480;

  localparam pixel_t THRESH_HIGH = 8'd200;
  localparam pixel_t THRESH_LOW  = 8'd100;
  localparam pixel_t PIX_MAX     = 8'd255;

  // result queue sizing
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  typedef struct packed {
    pixel_t edge_pixel;
    logic   frame_last;
  } out_item_t;

endpackage

`default_nettype wire

// ----- design/sobet_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface sobet_in_if;
  import sobet_pkg::*;

  logic   valid;
  logic   ready;
  logic   op;
  pixel_t pixel;

  modport source (output valid, output op, output pixel, input ready);
  modport sink (input valid, input op, input pixel, output ready);

endinterface

`default_nettype wire

// ----- design/sobet_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface sobet_out_if;
  import sobet_pkg::*;

  logic   valid;
  logic   ready;
  pixel_t edge_pixel;
  logic   frame_last;

  modport source (output valid, output edge_pixel, output frame_last, input ready);
  modport sink (input valid, input edge_pixel, input frame_last, output ready);

endinterface

`default_nettype wire

// ----- design/sobet_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sobet_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- design/sobel_edge_threshold_filter.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Sobel 3x3 edge filter on a raster stream of 8-bit grey pixels, one pixel per clock
// sustained while the result queue has room. Each result is 255 minus the low byte
// of |Gx|+|Gy|, forced to 255 above 200 and to 0 below 100, and 0 on the image border;
// it leaves one row plus one pixel after its pixel, so op = 1 drain transactions (zero
// pixels) flush the last row at frame end. The two line stores share one RAM word per
// column, read when a pixel is taken and written back the next cycle with a bypass of
// the last write, which sets the one pixel per clock figure; a result passes the b and
// c stage registers before it is written into the output queue and can leave on the
// cycle after. After reset the RAM is zeroed, and no pixel is taken until that is done;
// configuration writes are taken at any time and should only change between frames.
module sobel_edge_threshold_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  sobet_in_if.sink                   in_stream,
  sobet_out_if.source                out_stream,
  input  wire logic                  cfg_we,
  input  wire sobet_pkg::cfg_idx_t   cfg_index,
  input  wire sobet_pkg::cfg_data_t  cfg_wdata
);
  import sobet_pkg::*;

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int KW   = AW + 1;
  localparam int HW   = $clog2(MAX_HEIGHT);
  localparam int HKW  = HW + 1;
  localparam int WEXT = (KW > CFG_W) ? KW : CFG_W;
  localparam int HEXT = (HKW > CFG_W) ? HKW : CFG_W;
  localparam int DW   = 2 * PIXEL_W;

  localparam logic [1:0] ROW_ZERO     = 2'd0;
  localparam logic [1:0] ROW_ONE      = 2'd1;
  localparam logic [1:0] ROW_TWO_PLUS = 2'd2;

  function automatic pixel_t edge_calc(input logic [8:0][PIXEL_W-1:0] wp);
    logic [PIXEL_W+1:0] right, left, bottom, upper, dx, dy;
    logic [PIXEL_W+2:0] sum;
    pixel_t             s, e, res;
    right  = (PIXEL_W+2)'(wp[2]) + ((PIXEL_W+2)'(wp[5]) << 1) + (PIXEL_W+2)'(wp[8]);
    left   = (PIXEL_W+2)'(wp[0]) + ((PIXEL_W+2)'(wp[3]) << 1) + (PIXEL_W+2)'(wp[6]);
    bottom = (PIXEL_W+2)'(wp[6]) + ((PIXEL_W+2)'(wp[7]) << 1) + (PIXEL_W+2)'(wp[8]);
    upper  = (PIXEL_W+2)'(wp[0]) + ((PIXEL_W+2)'(wp[1]) << 1) + (PIXEL_W+2)'(wp[2]);
    dx     = (right >= left) ? right - left : left - right;
    dy     = (bottom >= upper) ? bottom - upper : upper - bottom;
    sum    = (PIXEL_W+3)'(dx) + (PIXEL_W+3)'(dy);
    s      = sum[PIXEL_W-1:0];
    e      = PIX_MAX - s;
    if (e > THRESH_HIGH) begin
      res = PIX_MAX;
    end else if (e < THRESH_LOW) begin
      res = '0;
    end else begin
      res = e;
    end
    return res;
  endfunction

  // configuration
  cfg_data_t img_width_r, img_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_width_r  <= IMAGE_WIDTH_RST;
      img_height_r <= IMAGE_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  img_width_r  <= cfg_wdata;
        REG_IMAGE_HEIGHT: img_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [WEXT-1:0] wcfg_ext;
  logic [HEXT-1:0] hcfg_ext;
  logic [KW-1:0]   w_eff, w_m1;
  logic [HKW-1:0]  h_eff, h_m1;

  always_comb begin
    wcfg_ext = WEXT'(img_width_r);
    hcfg_ext = HEXT'(img_height_r);
    if (wcfg_ext < WEXT'(3)) begin
      w_eff = KW'(3);
    end else if (wcfg_ext > WEXT'(MAX_WIDTH)) begin
      w_eff = KW'(MAX_WIDTH);
    end else begin
      w_eff = KW'(wcfg_ext);
    end
    if (hcfg_ext < HEXT'(3)) begin
      h_eff = HKW'(3);
    end else if (hcfg_ext > HEXT'(MAX_HEIGHT)) begin
      h_eff = HKW'(MAX_HEIGHT);
    end else begin
      h_eff = HKW'(hcfg_ext);
    end
    w_m1 = w_eff - KW'(1);
    h_m1 = h_eff - HKW'(1);
  end

  // clearing pass over the line store RAM
  logic          clr_active_r;
  logic [AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(MAX_WIDTH - 1)) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  // pipeline registers
  logic               b_valid_r, b_emit_r, b_border_r, b_last_r;
  logic [AW-1:0]      b_col_r;
  pixel_t             b_v_r;
  logic               c_valid_r, c_border_r, c_last_r;
  logic [8:0][PIXEL_W-1:0] window_r, window_nxt;
  logic               lw_valid_r;
  logic [AW-1:0]      lw_col_r;
  logic [DW-1:0]      lw_data_r;

  // result queue
  out_item_t          fifo_mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0] fifo_cnt_r, fifo_cnt_nxt, credit;
  logic               push, pop;

  // input side
  logic           acc;
  pixel_t         in_v;
  logic [AW-1:0]  in_col_r, in_col_nxt, rd_col;
  logic [1:0]     in_row_r, in_row_nxt;
  logic [AW-1:0]  out_col_r, out_col_nxt;
  logic [HW-1:0]  out_row_r, out_row_nxt;
  logic [KW-1:0]  in_col_ext, in_col_p1, out_col_ext, out_col_p1;
  logic [HKW-1:0] out_row_ext;
  logic           emit, border, last;

  assign credit = fifo_cnt_r + FIFO_CW'(b_valid_r) + FIFO_CW'(c_valid_r);
  assign in_stream.ready = !clr_active_r && (credit < FIFO_CW'(FIFO_DEPTH));
  assign acc  = in_stream.valid && in_stream.ready;
  assign in_v = in_stream.op ? '0 : in_stream.pixel;

  always_comb begin
    in_col_ext  = KW'(in_col_r);
    in_col_p1   = in_col_ext + KW'(1);
    out_col_ext = KW'(out_col_r);
    out_col_p1  = out_col_ext + KW'(1);
    out_row_ext = HKW'(out_row_r);
    rd_col      = (in_col_ext >= w_eff) ? w_m1[AW-1:0] : in_col_r;
    emit        = (in_row_r == ROW_TWO_PLUS) || ((in_row_r == ROW_ONE) && (in_col_r != '0));
    border      = (out_row_r == '0) || (out_row_ext >= h_m1) ||
                  (out_col_r == '0) || (out_col_ext >= w_m1);
    last        = (out_row_ext >= h_m1) && (out_col_ext >= w_m1);

    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (acc) begin
      if (in_col_p1 >= w_eff) begin
        in_col_nxt = '0;
        if (in_row_r != ROW_TWO_PLUS) begin
          in_row_nxt = in_row_r + 2'd1;
        end
      end else begin
        in_col_nxt = in_col_p1[AW-1:0];
      end
      if (emit) begin
        if (last) begin
          // frame done: every position counter restarts
          in_col_nxt  = '0;
          in_row_nxt  = ROW_ZERO;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (out_col_p1 >= w_eff) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + HW'(1);
        end else begin
          out_col_nxt = out_col_p1[AW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= ROW_ZERO;
      out_col_r <= '0;
      out_row_r <= '0;
      b_valid_r <= 1'b0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      b_valid_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      b_col_r    <= rd_col;
      b_v_r      <= in_v;
      b_emit_r   <= emit;
      b_border_r <= border;
      b_last_r   <= last;
    end
  end

  // line store RAM: [DW-1:PIXEL_W] upper row, [PIXEL_W-1:0] middle row
  logic [DW-1:0] ram_rdata, col_data, ram_wdata;
  logic [AW-1:0] ram_waddr;
  logic          ram_we;

  // the previous transaction may have written this column in the cycle of our read
  assign col_data  = (lw_valid_r && (lw_col_r == b_col_r)) ? lw_data_r : ram_rdata;
  assign ram_we    = clr_active_r || b_valid_r;
  assign ram_waddr = clr_active_r ? clr_addr_r : b_col_r;
  assign ram_wdata = clr_active_r ? '0 : {col_data[PIXEL_W-1:0], b_v_r};

  sobet_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_col),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_valid_r <= 1'b0;
    end else if (b_valid_r) begin
      lw_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid_r) begin
      lw_col_r  <= b_col_r;
      lw_data_r <= ram_wdata;
    end
  end

  always_comb begin
    window_nxt = window_r;
    if (b_valid_r) begin
      for (int k = 0; k < 3; k++) begin
        window_nxt[3*k]   = window_r[3*k+1];
        window_nxt[3*k+1] = window_r[3*k+2];
      end
      window_nxt[2] = col_data[DW-1:PIXEL_W];
      window_nxt[5] = col_data[PIXEL_W-1:0];
      window_nxt[8] = b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r  <= '0;
      c_valid_r <= 1'b0;
    end else begin
      window_r  <= window_nxt;
      c_valid_r <= b_valid_r && b_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid_r) begin
      c_border_r <= b_border_r;
      c_last_r   <= b_last_r;
    end
  end

  // stage c: gradient of the updated window into the result queue
  out_item_t push_item;

  assign push_item.edge_pixel = c_border_r ? '0 : edge_calc(window_r);
  assign push_item.frame_last = c_last_r;
  assign push = c_valid_r;
  assign pop  = out_stream.valid && out_stream.ready;
  assign fifo_cnt_nxt = fifo_cnt_r + FIFO_CW'(push) - FIFO_CW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      fifo_cnt_r <= fifo_cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign out_stream.valid      = (fifo_cnt_r != '0);
  assign out_stream.edge_pixel = fifo_mem_r[rd_ptr_r].edge_pixel;
  assign out_stream.frame_last = fifo_mem_r[rd_ptr_r].frame_last;

  a_clear_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> (!b_valid_r && !in_stream.ready))
    else $error("pixel in flight during line store clearing");

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit <= FIFO_CW'(FIFO_DEPTH))
    else $error("results in flight exceed result queue space");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (fifo_cnt_r != FIFO_CW'(FIFO_DEPTH)))
    else $error("result pushed into a full queue");

  a_fwd_source: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && $past(b_valid_r)) |-> lw_valid_r)
    else $error("write bypass not armed after a line store write");

endmodule

`default_nettype wire
